// ===== hdl/arlm_pkg.sv =====
`timescale 1ns / 1ps
package arlm_pkg;
  localparam int SampleW = 32;
  localparam int LevelW = 17;
  localparam int SumW = 48;
  localparam int CountW = 13;
  localparam int MagW = 18;
  localparam int SqW = 36;
  localparam logic [CountW-1:0] CountHwMax = 13'd8191;
  localparam int MaxChunkDefault = 4096;
  localparam logic [16:0] GainQ16 = 17'd104858;
  localparam logic [LevelW-1:0] FullScale = 17'd65536;
  localparam logic [1:0] FmtInt16 = 2'd0;
  localparam logic [1:0] FmtFloat = 2'd1;

  // Sample magnitude in Q3.15, rounded, saturated; valid=0 for unsupported format
  function automatic logic [MagW:0] sample_mag(input logic [1:0] fmt,
                                               input logic [31:0] w);
    logic [7:0] ex;
    logic [23:0] man;
    logic [17:0] cap;
    logic [4:0] sh;
    logic [25:0] rnd;
    logic [17:0] mag;
    ex = w[30:23];
    man = {1'b1, w[22:0]};
    cap = w[31] ? 18'd131072 : 18'd131071;
    sh = '0;
    rnd = '0;
    mag = '0;
    if (fmt == FmtInt16) begin
      mag = w[15] ? (18'h10000 - {2'b0, w[15:0]}) : {2'b0, w[15:0]};
      sample_mag = {1'b1, mag};
    end else if (fmt == FmtFloat) begin
      if (ex == 8'd255) mag = (w[22:0] != '0) ? '0 : cap;
      else if (ex >= 8'd129) mag = cap;
      else if (ex == 8'd0 || ex < 8'd110) mag = '0;
      else begin
        sh = 5'(8'd135 - ex);
        rnd = ({2'b0, man} + (26'd1 << (sh - 5'd1))) >> sh;
        mag = (rnd > {8'b0, cap}) ? cap : rnd[17:0];
      end
      sample_mag = {1'b1, mag};
    end else begin
      sample_mag = '0;
    end
  endfunction
endpackage

// ===== hdl/arlm_divsqrt.sv =====
`timescale 1ns / 1ps
// Shared one-bit-per-cycle unit: restoring divide then two integer square roots, then gain scaling
module arlm_divsqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [arlm_pkg::SumW-1:0]       sum,
  input  logic [arlm_pkg::CountW-1:0]     count,
  output logic                            done,
  output logic [arlm_pkg::LevelW-1:0]     level
);
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SQ1, S_SQ2, S_MUL, S_DONE} state_t;
  state_t state;
  logic [5:0] step;
  logic [49:0] x;        // dividend / radicand shift register
  logic [33:0] rem;      // partial remainder
  logic [33:0] res;      // quotient or root
  logic [12:0] dvs;
  logic [35:0] trial;
  logic [33:0] prod;
  logic        div_ge;

  always_comb begin
    trial = {rem[33:0], x[49:48]} - {res[33:0], 2'b01};
    div_ge = ({rem[12:0], x[47]} >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          x <= {2'b0, sum};
          dvs <= count;
          rem <= '0;
          res <= '0;
          step <= 6'd47;
          state <= S_DIV;
        end
        // quotient bit per cycle
        S_DIV: begin
          if (div_ge) begin
            rem <= {20'b0, {rem[12:0], x[47]} - {1'b0, dvs}};
            res <= {res[32:0], 1'b1};
          end else begin
            rem <= {20'b0, rem[12:0], x[47]};
            res <= {res[32:0], 1'b0};
          end
          x <= {x[48:0], 1'b0};
          if (step == 0) state <= S_SQ1;
          else step <= step - 6'd1;
        end
        default: ;
      endcase
      // setup after divide: radicand = mean*4 (mean <= 2^34, 35 bits with last bit)
      if (state == S_DIV && step == 0) begin
        x <= {13'b0, res[33:0], div_ge, 2'b00};
        rem <= '0;
        res <= '0;
        step <= 6'd24;
      end
      // root digit per cycle over 2-bit groups
      if (state == S_SQ1 || state == S_SQ2) begin
        if (!trial[35]) begin
          rem <= trial[33:0];
          res <= {res[32:0], 1'b1};
        end else begin
          rem <= {rem[31:0], x[49:48]};
          res <= {res[32:0], 1'b0};
        end
        x <= {x[47:0], 2'b00};
        if (step == 0) begin
          state <= (state == S_SQ1) ? S_SQ2 : S_MUL;
        end else step <= step - 6'd1;
      end
      if (state == S_SQ1 && step == 0) begin
        // radicand = rms*65536 (rms <= 2^18, 19 bits with last root bit)
        x <= {15'b0, res[17:0], !trial[35], 16'b0};
        rem <= '0;
        res <= '0;
        step <= 6'd24;
      end
      if (state == S_MUL) begin
        prod <= res;
        state <= S_DONE;
      end
      if (state == S_DONE) begin
        done <= 1'b1;
        state <= S_IDLE;
      end
    end
  end

  logic [51:0] scaled;
  always_comb begin
    scaled = ({18'b0, prod} * {35'b0, arlm_pkg::GainQ16} + 52'd32768) >> 16;
    level = (scaled > {35'b0, arlm_pkg::FullScale}) ? arlm_pkg::FullScale
                                                   : scaled[arlm_pkg::LevelW-1:0];
  end
endmodule

// ===== hdl/audio_rms_level_meter.sv =====
`timescale 1ns / 1ps
// Non-last item: squared and accumulated when accepted, ready again next cycle.
// Last item: after it is accepted, one shared shift/subtract unit runs a
// 48-step divide and two 25-step square roots, then a gain multiply, before
// the result is valid. Input stays stalled until that result is taken.
// Reset (synchronous) clears format, sum, count, last level and output valid.
module audio_rms_level_meter #(
  parameter int MAX_CHUNK = arlm_pkg::MaxChunkDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] sample,
  input  logic        last,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [16:0] level,
  output logic        changed,
  output logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);
  localparam logic [12:0] Cap = (MAX_CHUNK < 8191) ? 13'(MAX_CHUNK) : arlm_pkg::CountHwMax;
  logic [1:0] fmt;
  logic [47:0] square_sum;
  logic [12:0] sample_count;
  logic [16:0] last_level;
  logic busy, start, done;
  logic [16:0] lv;
  logic [18:0] m;
  logic [35:0] sq;
  logic [48:0] acc;

  assign cfg_ready = 1'b1;
  assign in_stall = busy || out_valid;

  always_comb begin
    m = arlm_pkg::sample_mag(fmt, sample);
    sq = {18'b0, m[17:0]} * {18'b0, m[17:0]};
    acc = {1'b0, square_sum} + {13'b0, sq};
  end

  arlm_divsqrt u_ds (.clk, .rst, .start, .sum(square_sum), .count(sample_count),
                     .done, .level(lv));

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= '0; square_sum <= '0; sample_count <= '0; last_level <= '0;
      busy <= 1'b0; start <= 1'b0; out_valid <= 1'b0;
    end else begin
      start <= 1'b0;
      if (cfg_valid) fmt <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      // accumulate
      if (in_valid && !in_stall) begin
        if (m[18] && sample_count < Cap) begin
          square_sum <= acc[48] ? '1 : acc[47:0];
          sample_count <= sample_count + 13'd1;
        end
        if (last) begin
          busy <= 1'b1;
          start <= 1'b1;
        end
      end
      // result
      if (done) begin
        busy <= 1'b0;
        out_valid <= 1'b1;
        level <= (sample_count == '0) ? '0 : lv;
        changed <= ((sample_count == '0) ? 17'd0 : lv) != last_level;
        last_level <= (sample_count == '0) ? '0 : lv;
        square_sum <= '0;
        sample_count <= '0;
      end
    end
  end
endmodule
